>>> rtl/srwb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwb_pkg: shared definitions for the sample ring window buffer
// Widths, command codes, configuration indexes and the structs that run
// between the front end, the back end and the remainder unit.
// ----------------------------------------------------------------------------
package srwb_pkg;

   // Ring geometry; CAPACITY must be a power of two (slot = low index bits)
   localparam int CAPACITY       = 65536;
   localparam int INDEX_BITS     = 48;
   localparam int SLOT_BITS      = $clog2(CAPACITY);
   localparam int COUNT_BITS     = SLOT_BITS + 1;

   // Word field widths
   localparam int KIND_BITS      = 2;
   localparam int SAMPLE_BITS    = 16;
   localparam int OFFSET_BITS    = 16;
   localparam int REG_BITS       = 17;
   localparam int CMP_BITS       = (REG_BITS > COUNT_BITS) ? REG_BITS : COUNT_BITS;

   // Front-to-back queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

   // Remainder unit: one dividend bit per cycle
   localparam int DIV_STEPS      = INDEX_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);

   // Control registers
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [REG_BITS-1:0] RESET_WINDOW_LENGTH = REG_BITS'(16000);
   localparam logic [REG_BITS-1:0] RESET_HOP_LENGTH    = REG_BITS'(8000);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH    = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_REQUEST = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_HOP_LENGTH    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ_WAIT,
      BK_REQ_CHECK,
      BK_REQ_DIV,
      BK_REQ_FIT,
      BK_REPLY
   } back_state_type;

   // One classified input word
   typedef struct packed {
      kind_type                      kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          start_given;
      logic [INDEX_BITS-1:0]         requested_start;
      logic [OFFSET_BITS-1:0]        offset;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [REG_BITS-1:0] window_length;
      logic [REG_BITS-1:0] hop_length;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [INDEX_BITS-1:0] dividend;
      logic [REG_BITS-1:0]   divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic                busy;
      logic [REG_BITS-1:0] remainder;
   } rem_stat_type;

endpackage

>>> rtl/srwb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwb_if: request and response channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface srwb_req_if;
   import srwb_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [KIND_BITS-1:0]          kind;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          start_given;
   logic [INDEX_BITS-1:0]         requested_start;
   logic [OFFSET_BITS-1:0]        offset;

   modport source (output valid, kind, sample, start_given, requested_start, offset,
                   input ready);
   modport sink   (input valid, kind, sample, start_given, requested_start, offset,
                   output ready);
endinterface

interface srwb_rsp_if;
   import srwb_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [INDEX_BITS-1:0]         win_base;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, ok, win_base, sample_out, input ready);
   modport sink   (input valid, ok, win_base, sample_out, output ready);
endinterface

>>> rtl/srwb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwb_front: request intake and command queue
// Decodes each request word into a command and holds it in a short FIFO
// until the back end takes it.
// ----------------------------------------------------------------------------
module srwb_front (
   input  logic                     clock,
   input  logic                     reset,
   srwb_req_if.sink                 req,
   output srwb_pkg::queue_head_type head,
   input  logic                     pop
);
   import srwb_pkg::*;

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   fill_ff, fill_in;
   logic                 push;
   cmd_type              cmd;

   // classify the incoming word
   always_comb begin
      cmd.kind            = kind_type'(req.kind);
      cmd.sample          = req.sample;
      cmd.start_given     = req.start_given;
      cmd.requested_start = req.requested_start;
      cmd.offset          = req.offset;
   end

   assign req.ready  = (fill_ff != (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

>>> rtl/srwb_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwb_rem: serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module srwb_rem (
   input  logic                   clock,
   input  logic                   reset,
   input  srwb_pkg::rem_cmd_type  cmd,
   output srwb_pkg::rem_stat_type stat
);
   import srwb_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0]   dvd_ff, dvd_in;
   logic [REG_BITS-1:0]     rem_ff, rem_in;
   logic [REG_BITS-1:0]     dsr_ff, dsr_in;
   logic [REG_BITS:0]       trial;
   logic [REG_BITS:0]       trial_sub;

   // shift in the next dividend bit and try the subtract
   assign trial     = {rem_ff, dvd_ff[INDEX_BITS-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[INDEX_BITS-2:0], 1'b0};
         rem_in = (trial >= {1'b0, dsr_ff}) ? trial_sub[REG_BITS-1:0] : trial[REG_BITS-1:0];
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.remainder = rem_ff;

endmodule

>>> rtl/srwb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwb_back: ring state, sample memory and command execution
// Pops commands from the queue, updates the ring indices, grants windows
// and reads samples; results leave through a registered response stage.
// ----------------------------------------------------------------------------
module srwb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  srwb_pkg::cfg_type        cfg,
   input  srwb_pkg::queue_head_type head,
   output logic                     pop,
   output srwb_pkg::rem_cmd_type    rem_cmd,
   input  srwb_pkg::rem_stat_type   rem_stat,
   srwb_rsp_if.source               rsp
);
   import srwb_pkg::*;

   back_state_type state_ff, state_in;

   // ring indices
   logic [INDEX_BITS-1:0] next_ff, next_in;
   logic [INDEX_BITS-1:0] oldest_ff, oldest_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [INDEX_BITS-1:0] granted_ff, granted_in;

   // window request working registers
   logic                  held_ok_ff, held_ok_in;
   logic [INDEX_BITS-1:0] last_ff, last_in;
   logic [COUNT_BITS-1:0] span_ff, span_in;
   logic [INDEX_BITS-1:0] start_ff, start_in;
   logic                  res_ok_ff, res_ok_in;
   logic [INDEX_BITS-1:0] res_start_ff, res_start_in;
   logic                  rd_ok_ff, rd_ok_in;

   // response stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [INDEX_BITS-1:0]         rsp_start_ff, rsp_start_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   // sample memory
   logic signed [SAMPLE_BITS-1:0] mem [CAPACITY];
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic                          mem_we;
   logic                          mem_re;
   logic [INDEX_BITS-1:0]         rd_index;

   logic                  out_free;
   logic                  issue;
   logic                  push_room;
   logic                  ring_full;
   logic                  off_ok;
   logic [INDEX_BITS-1:0] last_now;
   logic                  start_ge;
   logic                  start_le;
   logic [INDEX_BITS-1:0] behind;
   logic [REG_BITS-1:0]   extra;
   logic                  fits;
   logic [INDEX_BITS-1:0] fit_start;

   // shared decode
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign issue     = head.valid &&
                      (out_free || !(head.cmd.kind inside {KIND_PUSH, KIND_CLEAR}));
   assign push_room = (next_ff != '1);
   assign ring_full = (count_ff == COUNT_BITS'(CAPACITY));
   assign off_ok    = (REG_BITS'(head.cmd.offset) < cfg.window_length);
   assign rd_index  = granted_ff + INDEX_BITS'(head.cmd.offset);
   assign last_now  = next_ff - INDEX_BITS'(cfg.window_length);

   // request checks on the registered start
   assign start_ge  = (start_ff >= oldest_ff);
   assign start_le  = (start_ff <= last_ff);
   assign behind    = oldest_ff - start_ff;

   // hop alignment after the remainder
   assign extra     = (rem_stat.remainder == '0) ? '0 : cfg.hop_length - rem_stat.remainder;
   assign fits      = (CMP_BITS'(extra) <= CMP_BITS'(span_ff));
   assign fit_start = oldest_ff + INDEX_BITS'(extra);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (issue) begin
               if (head.cmd.kind == KIND_READ) begin
                  state_in = BK_READ_WAIT;
               end else if (head.cmd.kind == KIND_REQUEST) begin
                  state_in = BK_REQ_CHECK;
               end
            end
         end
         BK_READ_WAIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_REQ_CHECK: begin
            if (held_ok_ff && !start_ge && cfg.hop_length != '0) begin
               state_in = BK_REQ_DIV;
            end else begin
               state_in = BK_REPLY;
            end
         end
         BK_REQ_DIV: begin
            if (!rem_stat.busy) begin
               state_in = BK_REQ_FIT;
            end
         end
         BK_REQ_FIT: begin
            state_in = BK_REPLY;
         end
         BK_REPLY: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop              = 1'b0;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      rem_cmd.start    = 1'b0;
      rem_cmd.dividend = behind;
      rem_cmd.divisor  = cfg.hop_length;
      next_in          = next_ff;
      oldest_in        = oldest_ff;
      count_in         = count_ff;
      granted_in       = granted_ff;
      held_ok_in       = held_ok_ff;
      last_in          = last_ff;
      span_in          = span_ff;
      start_in         = start_ff;
      res_ok_in        = res_ok_ff;
      res_start_in     = res_start_ff;
      rd_ok_in         = rd_ok_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      rsp_ok_in        = rsp_ok_ff;
      rsp_start_in     = rsp_start_ff;
      rsp_sample_in    = rsp_sample_ff;
      case (state_ff)
         BK_IDLE: begin
            if (issue) begin
               pop = 1'b1;
               case (head.cmd.kind)
                  KIND_PUSH: begin
                     rsp_valid_in  = 1'b1;
                     rsp_ok_in     = push_room;
                     rsp_start_in  = '0;
                     rsp_sample_in = '0;
                     if (push_room) begin
                        mem_we  = 1'b1;
                        next_in = next_ff + 1'b1;
                        if (ring_full) begin
                           oldest_in = oldest_ff + 1'b1;
                        end else begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     rsp_ok_in     = 1'b1;
                     rsp_start_in  = '0;
                     rsp_sample_in = '0;
                     oldest_in     = next_ff;
                     count_in      = '0;
                  end
                  KIND_READ: begin
                     mem_re   = 1'b1;
                     rd_ok_in = off_ok;
                  end
                  KIND_REQUEST: begin
                     held_ok_in = (CMP_BITS'(count_ff) >= CMP_BITS'(cfg.window_length));
                     last_in    = last_now;
                     span_in    = count_ff - COUNT_BITS'(cfg.window_length);
                     start_in   = head.cmd.start_given ? head.cmd.requested_start : last_now;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = rd_ok_ff;
               rsp_start_in  = granted_ff;
               rsp_sample_in = rd_ok_ff ? rdata_ff : '0;
            end
         end
         BK_REQ_CHECK: begin
            if (!held_ok_ff) begin
               res_ok_in    = 1'b0;
               res_start_in = '0;
            end else if (start_ge) begin
               res_ok_in    = start_le;
               res_start_in = start_ff;
               if (start_le) begin
                  granted_in = start_ff;
               end
            end else if (cfg.hop_length == '0) begin
               // zero hop: snap to the oldest held sample
               res_ok_in    = 1'b1;
               res_start_in = oldest_ff;
               granted_in   = oldest_ff;
            end else begin
               rem_cmd.start = 1'b1;
            end
         end
         BK_REQ_FIT: begin
            res_ok_in    = fits;
            res_start_in = fit_start;
            if (fits) begin
               granted_in = fit_start;
            end
         end
         BK_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = res_ok_ff;
               rsp_start_in  = res_ok_ff ? res_start_ff : '0;
               rsp_sample_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         next_ff      <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         granted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         granted_ff   <= granted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_ok_ff    <= held_ok_in;
      last_ff       <= last_in;
      span_ff       <= span_in;
      start_ff      <= start_in;
      res_ok_ff     <= res_ok_in;
      res_start_ff  <= res_start_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // sample memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[next_ff[SLOT_BITS-1:0]] <= head.cmd.sample;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_index[SLOT_BITS-1:0]];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ok         = rsp_ok_ff;
   assign rsp.win_base   = rsp_start_ff;
   assign rsp.sample_out = rsp_sample_ff;

endmodule

>>> rtl/sample_ring_window_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_ring_window_buffer_core: sliding window ring of Q1.15 samples
// Push, clear, window grant and window read over a 65536-entry sample ring.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (push, clear, window request, read); rsp
//   returns exactly one result word for each, in order. csr_we/csr_index/
//   csr_wdata set window_length and hop_length; the user must write them
//   only while the block is idle, as the block does not enforce it.
//   Accepted words wait in a 4-deep queue; req.ready drops only when it fills.
//   Each word passes the queue and the response register; a read also
//   passes the memory read register, a window request its check and reply
//   states and, to align a stale start to the hop, the remainder unit, one
//   bit per cycle over the 48-bit index distance. Push and clear go at one
//   word per cycle while rsp.ready is high; reads do not overlap.
//   Reset empties the ring and zeros all indices and the granted start; the
//   sample memory keeps its contents and is not swept, so it is ready at
//   once. When rsp.ready is low the result holds, the back end stops at the
//   next result and the queue absorbs up to four more words.
// ----------------------------------------------------------------------------
module sample_ring_window_buffer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   srwb_req_if.sink                             req,
   srwb_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [srwb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [srwb_pkg::REG_BITS-1:0]        csr_wdata
);
   import srwb_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;
   rem_cmd_type    rem_cmd;
   rem_stat_type   rem_stat;

   // control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: cfg_in.window_length = csr_wdata;
            CSR_HOP_LENGTH:    cfg_in.hop_length    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= RESET_WINDOW_LENGTH;
         cfg_ff.hop_length    <= RESET_HOP_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srwb_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .head  (head),
      .pop   (pop)
   );

   srwb_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .stat  (rem_stat)
   );

   srwb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .pop      (pop),
      .rem_cmd  (rem_cmd),
      .rem_stat (rem_stat),
      .rsp      (rsp)
   );

   // checks
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_rem_start_idle: assert property (@(posedge clock) disable iff (reset)
      rem_cmd.start |-> !rem_stat.busy)
      else $error("remainder unit started while busy");

   a_rem_runs: assert property (@(posedge clock) disable iff (reset)
      rem_cmd.start |=> rem_stat.busy)
      else $error("remainder unit did not start");

   a_reset_rsp_idle: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

endmodule
